// ===== rtl/morse_text_encoder_core_macros.svh =====
// Assertion macros for the Morse text encoder core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MORSE_TEXT_ENCODER_CORE_MACROS_SVH
`define MORSE_TEXT_ENCODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define MTE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTE_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/mte_pkg.sv =====
// Package for the Morse text encoder: symbol codes, code tables, descriptor type.
// No dependencies.
`default_nettype none

package mte_pkg;

   typedef logic [1:0] sym_type;

   localparam sym_type SYM_DOT  = 2'd0;
   localparam sym_type SYM_DASH = 2'd1;
   localparam sym_type SYM_BAR  = 2'd2;

   localparam int MAX_SYMS = 11;
   localparam int PRE_SYMS = 5;    // four-symbol code plus bar
   localparam int MAIN_SYMS = 6;   // five-symbol digit plus bar

   typedef logic [3:0] cnt_type;

   typedef struct packed {
      logic [MAX_SYMS-1:0][1:0] sym;
      cnt_type                  cnt;
      logic                     bad;    // final symbol of the burst is an error
   } desc_type;

   // Patterns are first-symbol-in-bit-0, dash = 1.
   localparam logic [4:0] LETTER_PAT [26] = '{
      5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
      5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
      5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
      5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011
   };

   localparam logic [2:0] LETTER_LEN [26] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
      3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
      3'd4, 3'd4
   };

   localparam logic [4:0] DIGIT_PAT [10] = '{
      5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
      5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
   };

   localparam logic [2:0] DIGIT_LEN = 3'd5;

   localparam logic [3:0] DIGRAPH_PAT = 4'b1111;
   localparam logic [3:0] C_PAT       = 4'b0101;

   localparam logic [7:0] CHR_LOW_A = 8'h61;
   localparam logic [7:0] CHR_LOW_C = 8'h63;
   localparam logic [7:0] CHR_LOW_H = 8'h68;
   localparam logic [7:0] CHR_LOW_Z = 8'h7A;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_SPACE = 8'h20;

endpackage

`default_nettype wire

// ===== rtl/mte_intf.sv =====
// Valid/ready channel interfaces for the Morse text encoder.
// No dependencies.
`default_nettype none

interface mte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] symbol;
   logic       bad_char;
   logic       last_of_run;

   modport source (output valid, output symbol, output bad_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input symbol, input bad_char, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/mte_decode.sv =====
// Byte classifier and code lookup; owns the held-c and whitespace-run state.
// Depends on mte_pkg.
`default_nettype none

module mte_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        text_byte,
   input  wire logic              end_of_text,
   input  wire logic              include_ch,
   output mte_pkg::desc_type      desc
);

   logic held_c_ff, held_c_in;
   logic psp_ff, psp_in;

   always_comb begin
      logic [7:0]           low;
      logic                 has_pre;
      logic                 done;
      logic [3:0]           pre_pat;
      logic [4:0]           main_pat;
      logic [2:0]           main_len;
      logic                 main_on;
      logic                 bad;
      mte_pkg::sym_type     pre_sym [mte_pkg::PRE_SYMS];
      mte_pkg::sym_type     main_sym [mte_pkg::MAIN_SYMS];
      mte_pkg::cnt_type     main_cnt;

      low      = text_byte | 8'h20;
      has_pre  = 1'b0;
      done     = 1'b0;
      pre_pat  = mte_pkg::C_PAT;
      main_pat = '0;
      main_len = '0;
      main_on  = 1'b0;
      bad      = 1'b0;
      held_c_in = 1'b0;
      psp_in   = psp_ff;

      if (held_c_ff) begin
         has_pre = 1'b1;
         if (low == mte_pkg::CHR_LOW_H) begin
            pre_pat = mte_pkg::DIGRAPH_PAT;
            done    = 1'b1;
            psp_in  = 1'b0;
         end
      end

      if (!done) begin
         if (text_byte == mte_pkg::CHR_SPACE || (text_byte >= 8'h09 && text_byte <= 8'h0D)) begin
            main_on = !psp_ff;          // bar is a code of length zero
            psp_in  = 1'b1;
         end else begin
            psp_in = 1'b0;
            if (text_byte == mte_pkg::CHR_DOT) begin
               main_on = 1'b1;
            end else if ((text_byte >= 8'h21 && text_byte <= 8'h2F) ||
                         (text_byte >= 8'h3A && text_byte <= 8'h40) ||
                         (text_byte >= 8'h5B && text_byte <= 8'h60) ||
                         (text_byte >= 8'h7B && text_byte <= 8'h7E)) begin
               main_on = 1'b0;
            end else if (low >= mte_pkg::CHR_LOW_A && low <= mte_pkg::CHR_LOW_Z) begin
               if (low == mte_pkg::CHR_LOW_C && include_ch && !end_of_text) begin
                  held_c_in = 1'b1;
               end else begin
                  main_on  = 1'b1;
                  main_pat = mte_pkg::LETTER_PAT[5'(low - mte_pkg::CHR_LOW_A)];
                  main_len = mte_pkg::LETTER_LEN[5'(low - mte_pkg::CHR_LOW_A)];
               end
            end else if (text_byte >= mte_pkg::CHR_ZERO && text_byte <= mte_pkg::CHR_NINE) begin
               main_on  = 1'b1;
               main_pat = mte_pkg::DIGIT_PAT[4'(text_byte - mte_pkg::CHR_ZERO)];
               main_len = mte_pkg::DIGIT_LEN;
            end else begin
               main_on = 1'b1;
               bad     = 1'b1;
            end
         end
      end

      if (end_of_text) begin
         held_c_in = 1'b0;
         psp_in    = 1'b0;
      end

      for (int k = 0; k < mte_pkg::PRE_SYMS; k++) begin
         if (k < 4) begin
            pre_sym[k] = pre_pat[k] ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
         end else begin
            pre_sym[k] = mte_pkg::SYM_BAR;
         end
      end

      // an error result carries a dot symbol and no bar
      for (int k = 0; k < mte_pkg::MAIN_SYMS; k++) begin
         if (bad) begin
            main_sym[k] = mte_pkg::SYM_DOT;
         end else if (k < int'(main_len)) begin
            main_sym[k] = main_pat[k] ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT;
         end else if (k == int'(main_len)) begin
            main_sym[k] = mte_pkg::SYM_BAR;
         end else begin
            main_sym[k] = mte_pkg::SYM_DOT;
         end
      end

      if (!main_on) begin
         main_cnt = '0;
      end else if (bad) begin
         main_cnt = 4'd1;
      end else begin
         main_cnt = {1'b0, main_len} + 4'd1;
      end

      for (int i = 0; i < mte_pkg::MAX_SYMS; i++) begin
         if (has_pre) begin
            if (i < mte_pkg::PRE_SYMS) begin
               desc.sym[i] = pre_sym[i];
            end else begin
               desc.sym[i] = main_sym[i - mte_pkg::PRE_SYMS];
            end
         end else if (i < mte_pkg::MAIN_SYMS) begin
            desc.sym[i] = main_sym[i];
         end else begin
            desc.sym[i] = mte_pkg::SYM_DOT;
         end
      end

      desc.cnt = (has_pre ? 4'(mte_pkg::PRE_SYMS) : 4'd0) + main_cnt;
      desc.bad = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_c_ff <= 1'b0;
         psp_ff    <= 1'b0;
      end else if (accept) begin
         held_c_ff <= held_c_in;
         psp_ff    <= psp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mte_serializer.sv =====
// Result register: shifts a registered symbol burst out one beat per cycle while rsp_chan.ready is high.
// Depends on mte_pkg and mte_rsp_if.
`default_nettype none

module mte_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load_valid,
   output logic                   load_ready,
   input  wire mte_pkg::desc_type load_desc,
   mte_rsp_if.source              rsp_chan
);

   logic [mte_pkg::MAX_SYMS-1:0][1:0] sym_ff;
   mte_pkg::cnt_type                  rem_ff;
   logic                              bad_ff;
   logic                              beat;
   logic                              on_last;

   assign on_last    = (rem_ff == 4'd1);
   assign beat       = rsp_chan.valid && rsp_chan.ready;
   assign load_ready = (rem_ff == 4'd0) || (beat && on_last);

   assign rsp_chan.valid       = (rem_ff != 4'd0);
   assign rsp_chan.symbol      = sym_ff[0];
   assign rsp_chan.bad_char    = bad_ff && on_last;
   assign rsp_chan.last_of_run = on_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (load_valid && load_ready) begin
         rem_ff <= load_desc.cnt;
      end else if (beat) begin
         rem_ff <= rem_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         sym_ff <= load_desc.sym;
         bad_ff <= load_desc.bad;
      end else if (beat) begin
         sym_ff <= {mte_pkg::SYM_DOT, sym_ff[mte_pkg::MAX_SYMS-1:1]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/morse_text_encoder_core.sv =====
// Morse text encoder core: bytes in, dot/dash/bar beats out.
// Flow: an accepted byte is registered in the descriptor stage, then loaded into the
// output shift register; one result beat per cycle while rsp_chan.ready is high. A byte
// has up to 11 results; one with none drains from the descriptor stage without a beat.
// The output shift register, one symbol per beat, sets the sustained rate.
// Reset (synchronous): clears the held c, the whitespace run and the digraph mode.
`default_nettype none

`include "morse_text_encoder_core_macros.svh"

module morse_text_encoder_core (
   input  wire logic clock,
   input  wire logic reset,
   mte_req_if.sink   req_chan,
   mte_rsp_if.source rsp_chan,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic csr_data
);

   logic              include_ch_ff;
   logic              req_beat;
   mte_pkg::desc_type dec_desc;
   mte_pkg::desc_type desc_ff;
   logic              desc_valid_ff;
   logic              ser_ready;
   logic              desc_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         include_ch_ff <= 1'b0;
      end else if (csr_valid) begin
         include_ch_ff <= csr_data;
      end
   end

   // empty bursts drain from the descriptor stage without a beat
   assign desc_take      = desc_valid_ff && ((desc_ff.cnt == 4'd0) || ser_ready);
   assign req_chan.ready = !desc_valid_ff || desc_take;
   assign req_beat       = req_chan.valid && req_chan.ready;

   mte_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_beat),
      .text_byte   (req_chan.text_byte),
      .end_of_text (req_chan.end_of_text),
      .include_ch  (include_ch_ff),
      .desc        (dec_desc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
      end else if (req_beat) begin
         desc_valid_ff <= 1'b1;
      end else if (desc_take) begin
         desc_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         desc_ff <= dec_desc;
      end
   end

   mte_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (desc_valid_ff && (desc_ff.cnt != 4'd0)),
      .load_ready (ser_ready),
      .load_desc  (desc_ff),
      .rsp_chan   (rsp_chan)
   );

   `MTE_ASSERT_IMPL(a_bad_is_last, clock, reset, rsp_chan.valid && rsp_chan.bad_char,
      rsp_chan.last_of_run && (rsp_chan.symbol == mte_pkg::SYM_DOT),
      "error beat must be a dotted last beat")
   `MTE_ASSERT_NEXT(a_run_continues, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run, rsp_chan.valid,
      "burst ended without a last beat")
   `MTE_ASSERT_NEXT(a_desc_loaded, clock, reset, req_beat, desc_valid_ff,
      "accepted byte lost before descriptor stage")
   `MTE_ASSERT_IMPL(a_burst_bound, clock, reset, desc_valid_ff,
      desc_ff.cnt <= 4'(mte_pkg::MAX_SYMS), "burst longer than eleven symbols")

endmodule

`default_nettype wire
